@@ src/ocm_pkg.sv @@
// Package for the oversampled current monitor: field widths, configuration and
// result structs, register codes and parameter defaults.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ocm_pkg;

	localparam int SAMPLE_W     = 12;
	localparam int LANE_SAMPLES = 4;
	localparam int LANE_SUM_W   = SAMPLE_W + 2;
	localparam int ROUND_SUM_W  = SAMPLE_W + 3;
	localparam int CH_W         = 4;
	localparam int AVG_W        = 16;
	localparam int GAIN_W       = 16;
	localparam int OFFSET_W     = 8;
	localparam int DEADBAND_W   = 10;
	localparam int CLAMP_W      = 13;
	localparam int VALUE_W      = 16;
	localparam int TOTAL_W      = 18;
	localparam int CFG_DATA_W   = 32;
	localparam int CFG_ADDR_W   = 5;

	localparam int ROUNDS_DEF           = 32;
	localparam int CURRENT_CHANNELS_DEF = 12;
	localparam int DIVISOR_DEF          = 16;

	localparam logic [GAIN_W-1:0]            CUR_GAIN_RST = 16'd4170;
	localparam logic signed [OFFSET_W-1:0]   CUR_OFFSET_RST = 8'sd9;
	localparam logic [DEADBAND_W-1:0]        DEADBAND_RST = 10'd20;
	localparam logic [CLAMP_W-1:0]           CLAMP_RST = 13'd4000;
	localparam logic [GAIN_W-1:0]            SUP_GAIN_RST = 16'd45057;

	typedef enum logic [2:0] {
		REG_CUR_GAIN   = 3'd0,
		REG_CUR_OFFSET = 3'd1,
		REG_DEADBAND   = 3'd2,
		REG_CLAMP      = 3'd3,
		REG_SUP_GAIN   = 3'd4
	} ocm_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0]          cur_gain;
		logic signed [OFFSET_W-1:0] cur_offset;
		logic [DEADBAND_W-1:0]      deadband;
		logic [CLAMP_W-1:0]         clamp_limit;
		logic [GAIN_W-1:0]          sup_gain;
	} ocm_cfg_t;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		logic            bank;
		logic            supply;
	} ocm_meta_t;

	typedef struct packed {
		logic [CH_W-1:0]           channel;
		logic                      bank;
		logic                      is_supply;
		logic signed [VALUE_W-1:0] value;
		logic                      total_valid;
		logic signed [TOTAL_W-1:0] total;
	} ocm_result_t;

endpackage

@@ src/ocm_lane.sv @@
// One summing lane: adds the four results of one converter within a round.
// Depends on ocm_pkg for the sample and lane sum widths.
`timescale 1ns / 1ps

module ocm_lane import ocm_pkg::*; (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [SAMPLE_W-1:0]   sample [LANE_SAMPLES],
	output logic signed [LANE_SUM_W-1:0] sum_s1
);

	logic signed [LANE_SUM_W-1:0] sum;

	always_comb begin
		sum = '0;
		for (int i = 0; i < LANE_SAMPLES; i++) begin
			sum = sum + LANE_SUM_W'(sample[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= sum;
		end
	end

endmodule

@@ src/ocm_merge.sv @@
// Merging stage: adds the two lane sums into the round accumulator, counts rounds
// and steps the channel and bank sequence. Emits one event per finished channel.
// Depends on ocm_pkg for widths and the event metadata struct.
`timescale 1ns / 1ps

module ocm_merge import ocm_pkg::*; #(
	parameter int ROUNDS           = ROUNDS_DEF,
	parameter int CURRENT_CHANNELS = CURRENT_CHANNELS_DEF,
	parameter int ACC_W            = ROUND_SUM_W + $clog2(ROUNDS_DEF)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_take,
	input  logic signed [LANE_SUM_W-1:0] lane_a,
	input  logic signed [LANE_SUM_W-1:0] lane_b,
	output logic                         ev_valid_s2,
	input  logic                         ev_ready,
	output logic signed [ACC_W-1:0]      ev_acc_s2,
	output ocm_meta_t                    ev_meta_s2
);

	localparam int CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
	localparam logic [CNT_W-1:0] LAST_ROUND = CNT_W'(ROUNDS - 1);
	localparam logic [CH_W-1:0]  SUPPLY_CH = CH_W'(CURRENT_CHANNELS);

	logic [CNT_W-1:0]        cnt_q;
	logic [CH_W-1:0]         ch_q;
	logic                    bank_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_sum;
	logic                    finish;
	logic                    supply;

	assign in_take = !ev_valid_s2 || ev_ready;
	assign acc_sum = acc_q + ACC_W'(lane_a) + ACC_W'(lane_b);
	assign finish  = (cnt_q == LAST_ROUND);
	assign supply  = (ch_q == SUPPLY_CH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ch_q        <= '0;
			bank_q      <= 1'b0;
			acc_q       <= '0;
			ev_valid_s2 <= 1'b0;
			ev_acc_s2   <= '0;
			ev_meta_s2  <= '0;
		end else if (in_take) begin
			ev_valid_s2 <= in_valid && finish;
			if (in_valid) begin
				if (finish) begin
					acc_q      <= '0;
					cnt_q      <= '0;
					ev_acc_s2  <= acc_sum;
					ev_meta_s2 <= '{channel: ch_q, bank: bank_q, supply: supply};
					if (supply) begin
						ch_q   <= '0;
						bank_q <= !bank_q;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end else begin
					acc_q <= acc_sum;
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ src/ocm_cond.sv @@
// Conditioning pipeline: divides the channel sum by the divisor, scales the
// average, offsets, deadbands and clamps the currents, and keeps the running total.
// Depends on ocm_pkg for the configuration, metadata and result structs.
`timescale 1ns / 1ps

module ocm_cond import ocm_pkg::*; #(
	parameter int ACC_W   = ROUND_SUM_W + $clog2(ROUNDS_DEF),
	parameter int DIVISOR = DIVISOR_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ocm_cfg_t                cfg,
	input  logic                    ev_valid,
	output logic                    ev_ready,
	input  logic signed [ACC_W-1:0] ev_acc,
	input  ocm_meta_t               ev_meta,
	output logic                    res_valid_s6,
	input  logic                    res_ready,
	output ocm_result_t             res_s6
);

	// Division by the constant divisor: multiply by a rounded-up reciprocal and
	// shift. This is exact for every magnitude below 2**MAG_W.
	localparam int MAG_W   = ACC_W;
	localparam int DIV_L   = $clog2(DIVISOR);
	localparam int SHIFT   = MAG_W + DIV_L;
	localparam int RECIP_W = MAG_W + 1;
	localparam int PROD_W  = MAG_W + RECIP_W;
	localparam longint unsigned RECIP64 =
		((64'd1 << SHIFT) + longint'(DIVISOR) - 64'd1) / longint'(DIVISOR);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);
	localparam int SPROD_W = AVG_W + 1 + GAIN_W;
	localparam int SVAL_W  = AVG_W + 3;

	logic valid_s3, valid_s4, valid_s5;
	logic ready_s3, ready_s4, ready_s5, ready_s6;

	logic [PROD_W-1:0]         prod_s3;
	logic                      neg_s3;
	ocm_meta_t                 meta_s3;
	logic signed [AVG_W-1:0]   avg_s4;
	ocm_meta_t                 meta_s4;
	logic [SPROD_W-1:0]        sprod_s5;
	logic                      neg_s5;
	ocm_meta_t                 meta_s5;
	logic signed [TOTAL_W-1:0] total_q;

	logic [MAG_W-1:0]          acc_mag;
	logic [PROD_W-1:0]         quot;
	logic [AVG_W:0]            avg_mag;
	logic [GAIN_W-1:0]         gain;
	logic [AVG_W:0]            scaled;
	logic signed [SVAL_W-1:0]  sval;
	logic signed [SVAL_W-1:0]  cur_val;
	logic signed [SVAL_W-1:0]  db_ext;
	logic signed [SVAL_W-1:0]  lim_ext;
	logic signed [SVAL_W-1:0]  cond_val;

	assign ready_s6 = !res_valid_s6 || res_ready;
	assign ready_s5 = !valid_s5 || ready_s6;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ev_ready = ready_s3;

	assign acc_mag = ev_acc[ACC_W-1] ? MAG_W'(-ev_acc) : MAG_W'(ev_acc);
	assign quot    = prod_s3 >> SHIFT;
	assign avg_mag = avg_s4[AVG_W-1] ? (AVG_W+1)'(-(AVG_W+1)'(avg_s4))
	                                 : {1'b0, avg_s4};
	assign gain    = meta_s4.supply ? cfg.sup_gain : cfg.cur_gain;

	always_comb begin
		scaled  = sprod_s5[SPROD_W-1:GAIN_W];
		sval    = neg_s5 ? -SVAL_W'(scaled) : SVAL_W'(scaled);
		cur_val = sval + SVAL_W'(cfg.cur_offset);
		db_ext  = SVAL_W'(cfg.deadband);
		lim_ext = SVAL_W'(cfg.clamp_limit);
		// The deadband test takes precedence over the clamp.
		if (cur_val < db_ext && cur_val > -db_ext) begin
			cond_val = '0;
		end else if (cur_val > lim_ext) begin
			cond_val = lim_ext;
		end else if (cur_val < -lim_ext) begin
			cond_val = -lim_ext;
		end else begin
			cond_val = cur_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3     <= 1'b0;
			valid_s4     <= 1'b0;
			valid_s5     <= 1'b0;
			res_valid_s6 <= 1'b0;
			total_q      <= '0;
		end else begin
			if (ready_s3) valid_s3 <= ev_valid;
			if (ready_s4) valid_s4 <= valid_s3;
			if (ready_s5) valid_s5 <= valid_s4;
			if (ready_s6) begin
				res_valid_s6 <= valid_s5;
				if (valid_s5) begin
					if (!meta_s5.supply) begin
						total_q <= total_q + TOTAL_W'(cond_val);
					end else if (meta_s5.bank) begin
						total_q <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			prod_s3 <= PROD_W'(acc_mag) * PROD_W'(RECIP);
			neg_s3  <= ev_acc[ACC_W-1];
			meta_s3 <= ev_meta;
		end
		if (ready_s4) begin
			// The average wraps to 16 bits after the sign is restored.
			avg_s4  <= neg_s3 ? AVG_W'(-quot[AVG_W-1:0]) : quot[AVG_W-1:0];
			meta_s4 <= meta_s3;
		end
		if (ready_s5) begin
			sprod_s5 <= SPROD_W'(avg_mag) * SPROD_W'(gain);
			neg_s5   <= avg_s4[AVG_W-1];
			meta_s5  <= meta_s4;
		end
		if (ready_s6) begin
			res_s6.channel     <= meta_s5.channel;
			res_s6.bank        <= meta_s5.bank;
			res_s6.is_supply   <= meta_s5.supply;
			res_s6.value       <= meta_s5.supply ? VALUE_W'(sval) : VALUE_W'(cond_val);
			res_s6.total_valid <= meta_s5.supply && meta_s5.bank;
			res_s6.total       <= (meta_s5.supply && meta_s5.bank) ? total_q : '0;
		end
	end

endmodule

@@ src/oversampled_current_monitor.sv @@
// Top level of the oversampled current monitor: stream ports, register port,
// two summing lanes, the merging accumulator and the conditioning pipeline.
// Depends on ocm_pkg, ocm_lane, ocm_merge and ocm_cond.
//
//   Port group   Dir   Width  Contents
//   s_axis_*     in    96     one conversion round, eight signed results
//   m_axis_*     out   40+7   one finished channel result
//   p* (APB)     both  32     five configuration registers at 4*index
//
// One item is taken per clock while the output accepts; the single accumulator
// add in the merging stage sets that figure. The item that closes a channel's
// last round moves through s1 to s6. Reset clears all control state and loads
// the register defaults at once. A held result stalls only the stages behind
// it; items that finish no channel keep flowing while a bubble remains.
`timescale 1ns / 1ps

module oversampled_current_monitor import ocm_pkg::*; #(
	parameter int ROUNDS           = ROUNDS_DEF,
	parameter int CURRENT_CHANNELS = CURRENT_CHANNELS_DEF,
	parameter int DIVISOR          = DIVISOR_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// sample_a0, sample_a1, sample_a2, sample_a3, sample_b0, sample_b1,
	// sample_b2, sample_b3, 12 bits each
	input  logic [95:0]           s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// value (16), total (18), zero fill (6)
	output logic [39:0]           m_axis_tdata,
	// channel (4), bank (1), is_supply (1), total_valid (1)
	output logic [6:0]            m_axis_tuser,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int ACC_W = ROUND_SUM_W + $clog2(ROUNDS);

	ocm_cfg_t cfg_q;
	logic     cfg_wr;

	logic signed [SAMPLE_W-1:0]   samp_a [LANE_SAMPLES];
	logic signed [SAMPLE_W-1:0]   samp_b [LANE_SAMPLES];
	logic signed [LANE_SUM_W-1:0] lane_a_s1;
	logic signed [LANE_SUM_W-1:0] lane_b_s1;
	logic                         valid_s1;
	logic                         take_s1;

	logic                    ev_valid_s2;
	logic                    ev_ready;
	logic signed [ACC_W-1:0] ev_acc_s2;
	ocm_meta_t               ev_meta_s2;
	ocm_result_t             res_s6;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cur_gain    <= CUR_GAIN_RST;
			cfg_q.cur_offset  <= CUR_OFFSET_RST;
			cfg_q.deadband    <= DEADBAND_RST;
			cfg_q.clamp_limit <= CLAMP_RST;
			cfg_q.sup_gain    <= SUP_GAIN_RST;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_CUR_GAIN:   cfg_q.cur_gain    <= pwdata[GAIN_W-1:0];
				REG_CUR_OFFSET: cfg_q.cur_offset  <= pwdata[OFFSET_W-1:0];
				REG_DEADBAND:   cfg_q.deadband    <= pwdata[DEADBAND_W-1:0];
				REG_CLAMP:      cfg_q.clamp_limit <= pwdata[CLAMP_W-1:0];
				REG_SUP_GAIN:   cfg_q.sup_gain    <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_CUR_GAIN:   prdata = CFG_DATA_W'(cfg_q.cur_gain);
			REG_CUR_OFFSET: prdata = CFG_DATA_W'(cfg_q.cur_offset);
			REG_DEADBAND:   prdata = CFG_DATA_W'(cfg_q.deadband);
			REG_CLAMP:      prdata = CFG_DATA_W'(cfg_q.clamp_limit);
			REG_SUP_GAIN:   prdata = CFG_DATA_W'(cfg_q.sup_gain);
			default:        prdata = '0;
		endcase
	end

	always_comb begin
		for (int i = 0; i < LANE_SAMPLES; i++) begin
			samp_a[i] = s_axis_tdata[i*SAMPLE_W +: SAMPLE_W];
			samp_b[i] = s_axis_tdata[(i+LANE_SAMPLES)*SAMPLE_W +: SAMPLE_W];
		end
	end

	assign s_axis_tready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	ocm_lane u_lane_a (
		.clk    (clk),
		.en     (s_axis_tready),
		.sample (samp_a),
		.sum_s1 (lane_a_s1)
	);

	ocm_lane u_lane_b (
		.clk    (clk),
		.en     (s_axis_tready),
		.sample (samp_b),
		.sum_s1 (lane_b_s1)
	);

	ocm_merge #(
		.ROUNDS           (ROUNDS),
		.CURRENT_CHANNELS (CURRENT_CHANNELS),
		.ACC_W            (ACC_W)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid_s1),
		.in_take     (take_s1),
		.lane_a      (lane_a_s1),
		.lane_b      (lane_b_s1),
		.ev_valid_s2 (ev_valid_s2),
		.ev_ready    (ev_ready),
		.ev_acc_s2   (ev_acc_s2),
		.ev_meta_s2  (ev_meta_s2)
	);

	ocm_cond #(
		.ACC_W   (ACC_W),
		.DIVISOR (DIVISOR)
	) u_cond (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.ev_valid     (ev_valid_s2),
		.ev_ready     (ev_ready),
		.ev_acc       (ev_acc_s2),
		.ev_meta      (ev_meta_s2),
		.res_valid_s6 (m_axis_tvalid),
		.res_ready    (m_axis_tready),
		.res_s6       (res_s6)
	);

	assign m_axis_tdata = {6'd0, res_s6.total, res_s6.value};
	assign m_axis_tuser = {res_s6.total_valid, res_s6.is_supply, res_s6.bank,
	                       res_s6.channel};

endmodule

@@ src/ocm_checker.sv @@
// Port-level checks for the oversampled current monitor, bound to the top level.
// Depends on ocm_pkg for field widths and the clamp range.
`timescale 1ns / 1ps

module ocm_checker import ocm_pkg::*; #(
	parameter int CURRENT_CHANNELS = CURRENT_CHANNELS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [6:0]  m_axis_tuser
);

	localparam logic [CH_W-1:0] SUPPLY_CH = CH_W'(CURRENT_CHANNELS);
	localparam logic signed [VALUE_W-1:0] CUR_MAX = VALUE_W'((1 << CLAMP_W) - 1);

	// A result that is held back keeps every field.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("held result changed");

	// A total is only reported with the bank A supply result.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[6] |-> m_axis_tuser[5] && m_axis_tuser[4])
		else $error("total outside bank A supply result");

	// The total field reads zero whenever no total is reported.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[6] |-> m_axis_tdata[33:16] == '0)
		else $error("stale total shown");

	// The supply flag marks exactly the supply channel.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[5] == (m_axis_tuser[3:0] == SUPPLY_CH))
		else $error("supply flag and channel disagree");

	// A current never leaves the widest clamp range.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[5] |->
			$signed(m_axis_tdata[15:0]) <= CUR_MAX && $signed(m_axis_tdata[15:0]) >= -CUR_MAX)
		else $error("current beyond clamp range");

endmodule

bind oversampled_current_monitor ocm_checker #(
	.CURRENT_CHANNELS (CURRENT_CHANNELS)
) u_ocm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

@@ verif/oversampled_current_monitor_tb.sv @@
// Self-checking testbench for the oversampled current monitor: stream stimulus,
// APB register writes, and an in-order predictor of every channel result.
// Depends on ocm_pkg and the oversampled_current_monitor top level.
`timescale 1ns / 1ps

module oversampled_current_monitor_tb;
	import ocm_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = 12;
	localparam int DIRECTED_ROWS = CURRENT_CHANNELS_DEF + 1;
	localparam int FIRST_SPARE_REG = int'(REG_SUP_GAIN) + 1;
	localparam int SPARE_REGS    = 3;

	typedef enum logic [1:0] {SRC_FULL, SRC_QUIET, SRC_HIGH, SRC_RAILS} source_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] lane_a;
		logic signed [SAMPLE_W-1:0] lane_b;
		bit                         pinned;
	} row_t;

	typedef struct {
		int          ordinal;
		ocm_result_t want;
	} pin_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// sample_a0 .. sample_a3, sample_b0 .. sample_b3, 12 bits each, from bit 0 up
	logic [95:0]           s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// value (16), total (18), zero fill (6), from bit 0 up
	logic [39:0]           m_axis_tdata;
	// channel (4), bank (1), is_supply (1), total_valid (1), from bit 0 up
	logic [6:0]            m_axis_tuser;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// One bank B sweep after reset; the zero rows have results known by hand.
	row_t rows [DIRECTED_ROWS] = '{
		'{12'sd0,      12'sd0,      1'b1},
		'{12'sd2047,   12'sd2047,   1'b0},
		'{-12'sd2048,  -12'sd2048,  1'b0},
		'{12'sd2047,   -12'sd2048,  1'b0},
		'{-12'sd1,     -12'sd1,     1'b0},
		'{12'sd1,      12'sd1,      1'b0},
		'{12'sd100,    12'sd100,    1'b0},
		'{-12'sd100,   -12'sd100,   1'b0},
		'{12'sd5,      12'sd5,      1'b0},
		'{12'sd7,      12'sd7,      1'b0},
		'{-12'sd6,     -12'sd6,     1'b0},
		'{12'sd1365,   -12'sd1366,  1'b0},
		'{12'sd0,      12'sd0,      1'b1}
	};

	// Predictor state and configuration.
	ocm_cfg_t                  cfg;
	logic [4:0]                round_idx;
	logic [CH_W-1:0]           chan_idx;
	logic signed [19:0]        acc_sum;
	logic                      sweep_bank;
	logic signed [TOTAL_W-1:0] run_total;

	ocm_result_t conditioned_q [$];
	pin_t        pinned_q [$];

	int errors = 0;
	int rounds_sent = 0;
	int rounds_taken = 0;
	int readings_seen = 0;
	int totals_seen = 0;
	int settings_applied = 0;
	int burst_left = 0;
	int rx_left = 0;
	int rx_kind = 0;

	oversampled_current_monitor DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Adds one round to the running channel sum and, on the last round of a
	// channel, works out the conditioned reading it produces.
	task automatic fold_round(input logic [95:0] d);
		int          sum;
		int          avg_i;
		int          val;
		int          band;
		int          lim;
		ocm_result_t r;
		sum = acc_sum;
		for (int i = 0; i < 8; i++)
			sum += int'($signed(d[i*SAMPLE_W +: SAMPLE_W]));
		rounds_taken++;
		if (round_idx != 5'(ROUNDS_DEF - 1)) begin
			acc_sum = 20'(sum);
			round_idx = round_idx + 1'b1;
			return;
		end
		acc_sum = '0;
		round_idx = '0;
		avg_i = int'($signed(AVG_W'(sum / DIVISOR_DEF)));
		r = '0;
		r.channel = chan_idx;
		r.bank = sweep_bank;
		r.is_supply = (chan_idx >= CURRENT_CHANNELS_DEF);
		if (!r.is_supply) begin
			val = int'((longint'(avg_i) * longint'(cfg.cur_gain)) / 65536)
				+ int'($signed(cfg.cur_offset));
			band = int'(cfg.deadband);
			lim = int'(cfg.clamp_limit);
			// The deadband wins over the clamp when it is the wider of the two.
			if (val < band && val > -band)
				val = 0;
			else if (val > lim)
				val = lim;
			else if (val < -lim)
				val = -lim;
			run_total = TOTAL_W'(run_total + val);
			chan_idx = chan_idx + 1'b1;
		end else begin
			val = int'((longint'(avg_i) * longint'(cfg.sup_gain)) / 65536);
			if (sweep_bank) begin
				r.total_valid = 1'b1;
				r.total = run_total;
				run_total = '0;
			end
			chan_idx = '0;
			sweep_bank = ~sweep_bank;
		end
		r.value = VALUE_W'(val);
		if (pinned_q.size() != 0 && pinned_q[0].ordinal == rounds_taken) begin
			r = pinned_q[0].want;
			pinned_q.delete(0);
		end
		conditioned_q.push_back(r);
	endtask

	function automatic void compare_field(input string name, input logic signed [31:0] want,
		input logic signed [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endfunction

	task automatic check_reading(input logic [39:0] data, input logic [6:0] user);
		ocm_result_t w;
		if (conditioned_q.size() == 0) begin
			$error("unexpected result: channel %0d value %0d", user[3:0], $signed(data[15:0]));
			errors++;
			return;
		end
		w = conditioned_q.pop_front();
		readings_seen++;
		if (w.total_valid)
			totals_seen++;
		compare_field("channel", w.channel, user[3:0]);
		compare_field("bank", w.bank, user[4]);
		compare_field("is_supply", w.is_supply, user[5]);
		compare_field("total_valid", w.total_valid, user[6]);
		compare_field("value", w.value, $signed(data[15:0]));
		compare_field("total", w.total, $signed(data[33:16]));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				fold_round(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				check_reading(m_axis_tdata, m_axis_tuser);
		end
	end

	// Receiver: long ready stretches, hard stalls and random flicker.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_kind = $urandom_range(0, 9);
			rx_left = (rx_kind < 5) ? $urandom_range(1, 40) : $urandom_range(1, 12);
		end
		rx_left--;
		if (rx_kind < 5)
			m_axis_tready <= 1'b1;
		else if (rx_kind < 8)
			m_axis_tready <= 1'($urandom_range(0, 1));
		else
			m_axis_tready <= 1'b0;
	end

	task automatic send_round(input logic [95:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				s_axis_tdata <= {3{$urandom}};
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		rounds_sent++;
	endtask

	// Holds the sender until every reading has come out and the pipeline is empty.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (conditioned_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Bits above the register width are random; the block must ignore them.
	task automatic program_reg(input ocm_reg_t sel, input int value);
		logic [31:0] mask;
		logic [31:0] word;
		case (sel)
			REG_CUR_GAIN, REG_SUP_GAIN: mask = (32'd1 << GAIN_W) - 1;
			REG_CUR_OFFSET:             mask = (32'd1 << OFFSET_W) - 1;
			REG_DEADBAND:               mask = (32'd1 << DEADBAND_W) - 1;
			default:                    mask = (32'd1 << CLAMP_W) - 1;
		endcase
		word = ($urandom & ~mask) | (32'(value) & mask);
		apb_write(CFG_ADDR_W'({sel, 2'b00}), word);
		case (sel)
			REG_CUR_GAIN:   cfg.cur_gain = word[GAIN_W-1:0];
			REG_CUR_OFFSET: cfg.cur_offset = word[OFFSET_W-1:0];
			REG_DEADBAND:   cfg.deadband = word[DEADBAND_W-1:0];
			REG_CLAMP:      cfg.clamp_limit = word[CLAMP_W-1:0];
			default:        cfg.sup_gain = word[GAIN_W-1:0];
		endcase
	endtask

	task automatic apply_setting(input int gain, input int offset, input int band,
		input int limit, input int sgain);
		settle();
		program_reg(REG_CUR_GAIN, gain);
		program_reg(REG_CUR_OFFSET, offset);
		program_reg(REG_DEADBAND, band);
		program_reg(REG_CLAMP, limit);
		program_reg(REG_SUP_GAIN, sgain);
		settings_applied++;
	endtask

	function automatic logic [95:0] shape_round(input source_t main_src, input int main_pct);
		source_t     s;
		logic [95:0] d;
		int          pick;
		s = ($urandom_range(1, 100) <= main_pct) ? main_src : source_t'($urandom_range(0, 3));
		for (int i = 0; i < 8; i++) begin
			case (s)
				SRC_FULL:  d[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom);
				SRC_QUIET: d[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(0, 127) - 64);
				SRC_HIGH:  d[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(1600, 2047));
				default: begin
					pick = $urandom_range(0, 4);
					case (pick)
						0:       d[i*SAMPLE_W +: SAMPLE_W] = 12'h7FF;
						1:       d[i*SAMPLE_W +: SAMPLE_W] = 12'h800;
						2:       d[i*SAMPLE_W +: SAMPLE_W] = 12'h000;
						3:       d[i*SAMPLE_W +: SAMPLE_W] = 12'hFFF;
						default: d[i*SAMPLE_W +: SAMPLE_W] = 12'h001;
					endcase
				end
			endcase
		end
		return d;
	endfunction

	task automatic run_phase(input source_t src, input int pct, input int n, input int pause_at);
		for (int k = 0; k < n; k++) begin
			if (k == pause_at)
				settle();
			send_round(shape_round(src, pct));
		end
	endtask

	initial begin
		repeat (CYCLE_LIMIT)
			@(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		ocm_result_t want;
		pin_t        pin;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg.cur_gain = CUR_GAIN_RST;
		cfg.cur_offset = CUR_OFFSET_RST;
		cfg.deadband = DEADBAND_RST;
		cfg.clamp_limit = CLAMP_RST;
		cfg.sup_gain = SUP_GAIN_RST;
		round_idx = '0;
		chan_idx = '0;
		acc_sum = '0;
		sweep_bank = 1'b0;
		run_total = '0;
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed sweep of bank B at the reset settings, one row per channel.
		for (int row = 0; row < DIRECTED_ROWS; row++) begin
			if (rows[row].pinned) begin
				want = '0;
				want.channel = CH_W'(row);
				want.is_supply = (row == CURRENT_CHANNELS_DEF);
				pin.ordinal = rounds_sent + ROUNDS_DEF;
				pin.want = want;
				pinned_q.push_back(pin);
			end
			for (int k = 0; k < ROUNDS_DEF; k++)
				send_round({{4{rows[row].lane_b}}, {4{rows[row].lane_a}}});
		end

		// The first two random phases add up to one whole sweep, so the high-level
		// phase starts on bank B channel 0 and spans exactly one B and one A sweep.
		run_phase(SRC_QUIET, 50, 250, 120);
		apply_setting(0, -128, 0, 0, 0);
		run_phase(SRC_FULL, 60, 166, -1);

		// Full-scale gains and clamp drive the current total past its width.
		apply_setting(65535, 127, 0, 8191, 65535);
		for (int k = 0; k < SPARE_REGS; k++)
			apb_write(CFG_ADDR_W'((FIRST_SPARE_REG + k) * 4), $urandom);
		run_phase(SRC_HIGH, 100, 2 * DIRECTED_ROWS * ROUNDS_DEF, -1);

		// Deadband wider than the clamp.
		apply_setting(60000, -5, 1023, 300, 20000);
		run_phase(SRC_FULL, 50, 140, -1);

		apply_setting($urandom_range(0, 65535), $urandom_range(0, 255) - 128,
			$urandom_range(0, 200), $urandom_range(0, 8191), $urandom_range(0, 65535));
		run_phase(SRC_RAILS, 40, 48, -1);
		apply_setting($urandom_range(0, 65535), $urandom_range(0, 255) - 128,
			$urandom_range(0, 200), $urandom_range(0, 8191), $urandom_range(0, 65535));
		run_phase(SRC_FULL, 60, 48, -1);

		settle();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		$display("Ran %0d conversion rounds into %0d channel readings and %0d bank totals.",
			rounds_taken, readings_seen, totals_seen);
		$display("Used %0d register settings including both extremes and unused addresses.",
			settings_applied + 1);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/ocm_pkg.sv
src/ocm_lane.sv
src/ocm_merge.sv
src/ocm_cond.sv
src/oversampled_current_monitor.sv
src/ocm_checker.sv
verif/oversampled_current_monitor_tb.sv
